// ===== rtl/ptrd_pkg.sv =====
// package for the pure tone run detector
// widths, register codes, end causes and reset values; no dependencies
`default_nettype none

package ptrd_pkg;

  // field widths
  localparam int PULSE_W    = 16;
  localparam int COUNT_W    = 16;
  localparam int MINRUN_W   = 16;
  localparam int TOL_W      = 7;
  localparam int RATIO_W    = 4;
  localparam int FAIL_W     = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // datapath widths
  localparam int SUM_W    = PULSE_W + COUNT_W;
  localparam int PAIR_W   = PULSE_W + 1;
  localparam int MA_W     = COUNT_W + PAIR_W;
  localparam int MB_W     = PAIR_W;
  localparam int P_W      = MA_W + MB_W;
  localparam int CMP_W    = SUM_W + 8;
  localparam int TOLP_W   = SUM_W + TOL_W;
  localparam int CURN_W   = PULSE_W + COUNT_W;
  localparam int SILR_W   = SUM_W + RATIO_W;
  localparam int MAXC_W   = (COUNT_W > MINRUN_W) ? COUNT_W : MINRUN_W;
  localparam int DIV_CNT_W = $clog2(PULSE_W);

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [MB_W-1:0] MUL_HUNDRED     = MB_W'(100);
  localparam logic [MB_W-1:0] MUL_TWO_HUNDRED = MB_W'(200);

  // register reset values
  localparam logic [MINRUN_W-1:0] MIN_RUN_RST = MINRUN_W'(50);
  localparam logic [TOL_W-1:0]    TOL_RST     = TOL_W'(15);
  localparam logic [RATIO_W-1:0]  RATIO_RST   = RATIO_W'(5);
  localparam logic [FAIL_W-1:0]   FAIL_RST    = FAIL_W'(3);

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_RUN   = 2'd0,
    CFG_TOLERANCE = 2'd1,
    CFG_SILENCE   = 2'd2,
    CFG_FAIL      = 2'd3
  } cfg_idx_e;

  // end of attempt causes
  typedef enum logic [1:0] {
    CAUSE_SILENCE  = 2'd0,
    CAUSE_MISMATCH = 2'd1,
    CAUSE_EOD      = 2'd2
  } end_cause_e;

endpackage

`default_nettype wire

// ===== rtl/ptrd_if.sv =====
// valid/ready channel interfaces for pulses, results and register writes
// depends on ptrd_pkg
`default_nettype none

interface ptrd_in_if import ptrd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               start_req;
  logic [PULSE_W-1:0] pulse_len;
  logic               end_of_data;

  modport source (output valid, output start_req, output pulse_len, output end_of_data,
                  input ready);
  modport sink   (input valid, input start_req, input pulse_len, input end_of_data,
                  output ready);
endinterface

interface ptrd_out_if import ptrd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               detected;
  logic [COUNT_W-1:0] pulse_count;
  logic [PULSE_W-1:0] mean_len;
  logic [1:0]         end_cause;

  modport source (output valid, output detected, output pulse_count, output mean_len,
                  output end_cause, input ready);
  modport sink   (input valid, input detected, input pulse_count, input mean_len,
                  input end_cause, output ready);
endinterface

interface ptrd_cfg_if import ptrd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/ptrd_mul.sv =====
// shared multiplier with a registered product
// depends on ptrd_pkg
`default_nettype none

module ptrd_mul import ptrd_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic [MA_W-1:0] a_i,
  input  wire logic [MB_W-1:0] b_i,
  output logic      [P_W-1:0]  prod_o
);

  logic [P_W-1:0] prod_q;

  // one product per cycle
  always_ff @(posedge clk_i) begin
    prod_q <= P_W'(a_i) * P_W'(b_i);
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

// ===== rtl/ptrd_div.sv =====
// restoring divider, one quotient bit per cycle, for the run mean
// depends on ptrd_pkg; needs dividend high half below the divisor
`default_nettype none

module ptrd_div import ptrd_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [SUM_W-1:0]   dividend_i,
  input  wire logic [COUNT_W-1:0] divisor_i,
  output logic                    done_o,
  output logic      [PULSE_W-1:0] quotient_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [COUNT_W-1:0]   rem_q, rem_d;
  logic [PULSE_W-1:0]   quo_q, quo_d;
  logic [COUNT_W-1:0]   div_q, div_d;
  logic [COUNT_W:0]     trial;
  logic [COUNT_W:0]     trial_sub;
  logic                 ge;

  // shift in next dividend bit and try subtracting
  assign trial     = {rem_q, quo_q[PULSE_W-1]};
  assign ge        = trial >= {1'b0, div_q};
  assign trial_sub = trial - {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(PULSE_W - 1);
      rem_d  = dividend_i[SUM_W-1:PULSE_W];
      quo_d  = dividend_i[PULSE_W-1:0];
      div_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? trial_sub[COUNT_W-1:0] : trial[COUNT_W-1:0];
      quo_d = {quo_q[PULSE_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

// ===== rtl/pure_tone_run_detector.sv =====
// Pure tone run detector. Pulse lengths arrive on the input channel one per transfer. A
// pulse in a running attempt goes through a sequencer that uses one shared 33 x 17 bit
// multiplier six times and then compares; the input is ready again after the decision
// unless the attempt ends. When an attempt ends, the mean comes from a one bit per cycle
// divider; the result goes into the output register once the divider is done and the
// output register is free, and the input stays not ready until then. Registers are
// written on the configuration channel, which is always ready. Sources: ptrd_pkg,
// ptrd_if, ptrd_mul, ptrd_div.
`default_nettype none

module pure_tone_run_detector import ptrd_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ptrd_in_if.sink   in_ch,
  ptrd_out_if.source out_ch,
  ptrd_cfg_if.sink  cfg_ch
);

  // sequencer codes
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_PAIR   = 4'd1;
  localparam logic [3:0] S_LHS    = 4'd2;
  localparam logic [3:0] S_RHS    = 4'd3;
  localparam logic [3:0] S_TOL    = 4'd4;
  localparam logic [3:0] S_CURN   = 4'd5;
  localparam logic [3:0] S_SIL    = 4'd6;
  localparam logic [3:0] S_DIFF   = 4'd7;
  localparam logic [3:0] S_DECIDE = 4'd8;
  localparam logic [3:0] S_DIV    = 4'd9;
  localparam logic [3:0] S_EMIT   = 4'd10;

  logic [3:0] state_q, state_d;

  // configuration registers
  logic [MINRUN_W-1:0] min_run_q;
  logic [TOL_W-1:0]    tol_q;
  logic [RATIO_W-1:0]  ratio_q;
  logic [FAIL_W-1:0]   fail_lim_q;

  // run state
  logic               active_q;
  logic [SUM_W-1:0]   sum_q;
  logic [COUNT_W-1:0] count_q;
  logic [PULSE_W-1:0] prev_q;
  logic [FAIL_W-1:0]  mis_q;

  // per pulse working registers
  logic [PULSE_W-1:0] cur_q;
  logic [PAIR_W-1:0]  pair_q;
  logic [CMP_W-1:0]   lhs_q;
  logic [CMP_W-1:0]   rhs_q;
  logic [TOLP_W-1:0]  tolp_q;
  logic [CURN_W-1:0]  curn_q;
  logic [CMP_W-1:0]   diff_q;
  logic               sil_q;

  // pending result
  logic       det_q;
  end_cause_e cause_q;

  // output register
  logic               out_valid_q;
  logic               out_det_q;
  logic [COUNT_W-1:0] out_count_q;
  logic [PULSE_W-1:0] out_mean_q;
  logic [1:0]         out_cause_q;

  logic               in_xfer;
  logic               idle_eod_end;
  logic [MA_W-1:0]    mul_a;
  logic [MB_W-1:0]    mul_b;
  logic [P_W-1:0]     prod;
  logic               div_start;
  logic               div_done;
  logic [PULSE_W-1:0] mean;
  logic               mis;
  logic [FAIL_W:0]    fails;
  logic               base;
  logic               dec_fail_end;
  logic               dec_end;
  logic               out_load;

  assign in_ch.ready  = (state_q == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign idle_eod_end = in_xfer && in_ch.end_of_data && active_q;

  // decision terms
  assign mis   = diff_q > CMP_W'(tolp_q);
  assign fails = mis ? ({1'b0, mis_q} + 1'b1) : '0;
  assign base  = (sum_q != '0) && (MAXC_W'(count_q) >= MAXC_W'(min_run_q));
  assign dec_fail_end = fails > {1'b0, fail_lim_q};
  assign dec_end      = dec_fail_end || sil_q;

  assign div_start = idle_eod_end || ((state_q == S_DECIDE) && dec_end);
  assign out_load  = (state_q == S_EMIT) && (!out_valid_q || out_ch.ready);

  // multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_PAIR: begin
        mul_a = MA_W'(count_q);
        mul_b = pair_q;
      end
      S_LHS: begin
        mul_a = prod[MA_W-1:0];
        mul_b = MUL_HUNDRED;
      end
      S_RHS: begin
        mul_a = MA_W'(sum_q);
        mul_b = MUL_TWO_HUNDRED;
      end
      S_TOL: begin
        mul_a = MA_W'(sum_q);
        mul_b = MB_W'(tol_q);
      end
      S_CURN: begin
        mul_a = MA_W'(count_q);
        mul_b = MB_W'(cur_q);
      end
      S_SIL: begin
        mul_a = MA_W'(sum_q);
        mul_b = MB_W'(ratio_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  ptrd_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  ptrd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_q),
    .divisor_i  (count_q),
    .done_o     (div_done),
    .quotient_o (mean)
  );

  // sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (idle_eod_end) begin
          state_d = S_DIV;
        end else if (in_xfer && !in_ch.end_of_data && !in_ch.start_req && active_q) begin
          state_d = S_PAIR;
        end
      end
      S_PAIR:   state_d = S_LHS;
      S_LHS:    state_d = S_RHS;
      S_RHS:    state_d = S_TOL;
      S_TOL:    state_d = S_CURN;
      S_CURN:   state_d = S_SIL;
      S_SIL:    state_d = S_DIFF;
      S_DIFF:   state_d = S_DECIDE;
      S_DECIDE: state_d = dec_end ? S_DIV : S_IDLE;
      S_DIV: begin
        if (div_done) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control and run state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      min_run_q  <= MIN_RUN_RST;
      tol_q      <= TOL_RST;
      ratio_q    <= RATIO_RST;
      fail_lim_q <= FAIL_RST;
      active_q   <= 1'b0;
      sum_q      <= '0;
      count_q    <= '0;
      prev_q     <= '0;
      mis_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      // register writes
      if (cfg_ch.valid) begin
        unique case (cfg_ch.index)
          CFG_MIN_RUN:   min_run_q  <= cfg_ch.data[MINRUN_W-1:0];
          CFG_TOLERANCE: tol_q      <= cfg_ch.data[TOL_W-1:0];
          CFG_SILENCE:   ratio_q    <= cfg_ch.data[RATIO_W-1:0];
          CFG_FAIL:      fail_lim_q <= cfg_ch.data[FAIL_W-1:0];
          default: ;
        endcase
      end

      // attempt start and end of data
      if (idle_eod_end) begin
        active_q <= 1'b0;
      end else if (in_xfer && !in_ch.end_of_data && in_ch.start_req) begin
        active_q <= 1'b1;
        sum_q    <= SUM_W'(in_ch.pulse_len);
        count_q  <= COUNT_W'(1);
        prev_q   <= in_ch.pulse_len;
        mis_q    <= '0;
      end

      // pulse decision
      if (state_q == S_DECIDE) begin
        if (dec_end) begin
          active_q <= 1'b0;
        end else begin
          mis_q  <= fails[FAIL_W-1:0];
          prev_q <= cur_q;
          if (count_q != COUNT_MAX) begin
            sum_q   <= sum_q + SUM_W'(cur_q);
            count_q <= count_q + 1'b1;
          end
        end
      end

      // output valid
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // working and payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cur_q  <= in_ch.pulse_len;
      pair_q <= PAIR_W'(prev_q) + PAIR_W'(in_ch.pulse_len);
    end
    if (state_q == S_RHS)  lhs_q  <= prod[CMP_W-1:0];
    if (state_q == S_TOL)  rhs_q  <= prod[CMP_W-1:0];
    if (state_q == S_CURN) tolp_q <= prod[TOLP_W-1:0];
    if (state_q == S_SIL)  curn_q <= prod[CURN_W-1:0];
    if (state_q == S_DIFF) begin
      sil_q  <= SILR_W'(curn_q) >= prod[SILR_W-1:0];
      diff_q <= (lhs_q > rhs_q) ? (lhs_q - rhs_q) : (rhs_q - lhs_q);
    end

    // pending result flags
    if (idle_eod_end) begin
      det_q   <= 1'b0;
      cause_q <= CAUSE_EOD;
    end else if ((state_q == S_DECIDE) && dec_end) begin
      if (dec_fail_end) begin
        det_q   <= base && sil_q;
        cause_q <= CAUSE_MISMATCH;
      end else begin
        det_q   <= base;
        cause_q <= CAUSE_SILENCE;
      end
    end

    if (out_load) begin
      out_det_q   <= det_q;
      out_count_q <= count_q;
      out_mean_q  <= mean;
      out_cause_q <= cause_q;
    end
  end

  assign out_ch.valid       = out_valid_q;
  assign out_ch.detected    = out_det_q;
  assign out_ch.pulse_count = out_count_q;
  assign out_ch.mean_len    = out_mean_q;
  assign out_ch.end_cause   = out_cause_q;

endmodule

`default_nettype wire

// ===== rtl/ptrd_checker.sv =====
// port level checks for the pure tone run detector, bound to the top level
// depends on ptrd_pkg and pure_tone_run_detector
`default_nettype none

module ptrd_checker import ptrd_pkg::*; (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_ready_i,
  input wire logic               out_valid_i,
  input wire logic               out_ready_i,
  input wire logic               detected_i,
  input wire logic [COUNT_W-1:0] pulse_count_i,
  input wire logic [PULSE_W-1:0] mean_len_i,
  input wire logic [1:0]         end_cause_i
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(detected_i) && $stable(pulse_count_i) &&
      $stable(mean_len_i) && $stable(end_cause_i))
    else $error("result changed while stalled");

  // a new result only comes out of the busy sequencer
  a_out_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_ready_i))
    else $error("result appeared without a finished attempt");

  // end cause is one of the defined codes
  a_cause_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (end_cause_i == CAUSE_SILENCE || end_cause_i == CAUSE_MISMATCH ||
                     end_cause_i == CAUSE_EOD))
    else $error("undefined end cause");

  // a detected tone ends on a pulse and has counted pulses
  a_detect_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && detected_i |-> end_cause_i != CAUSE_EOD && pulse_count_i != '0)
    else $error("detection inconsistent with cause or count");

endmodule

bind pure_tone_run_detector ptrd_checker u_ptrd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_i    (in_ch.ready),
  .out_valid_i   (out_ch.valid),
  .out_ready_i   (out_ch.ready),
  .detected_i    (out_ch.detected),
  .pulse_count_i (out_ch.pulse_count),
  .mean_len_i    (out_ch.mean_len),
  .end_cause_i   (out_ch.end_cause)
);

`default_nettype wire

// ===== verif/pure_tone_run_detector_tb.sv =====
`timescale 1ns / 1ps
// testbench for pure_tone_run_detector: directed and random pulse trains, checked per result
// against an in-bench model of the detector; depends on ptrd_pkg, ptrd_if and the rtl

module pure_tone_run_detector_tb import ptrd_pkg::*;;

  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned IDLE_PCT = 21;

  typedef struct packed {
    logic               detected;
    logic [COUNT_W-1:0] pulse_count;
    logic [PULSE_W-1:0] mean_len;
    end_cause_e         end_cause;
  } tone_report_t;

  logic clk;
  logic rst_n;

  ptrd_in_if  in_ch ();
  ptrd_out_if out_ch ();
  ptrd_cfg_if cfg_ch ();

  pure_tone_run_detector dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // register copies
  logic [MINRUN_W-1:0] cfg_min_run = MIN_RUN_RST;
  logic [TOL_W-1:0]    cfg_tol     = TOL_RST;
  logic [RATIO_W-1:0]  cfg_ratio   = RATIO_RST;
  logic [FAIL_W-1:0]   cfg_fail    = FAIL_RST;

  // detector state copy
  bit                  tone_active = 1'b0;
  logic [SUM_W-1:0]    tone_sum    = '0;
  logic [COUNT_W-1:0]  tone_count  = '0;
  logic [PULSE_W-1:0]  last_pulse  = '0;
  logic [FAIL_W-1:0]   miss_run    = '0;

  tone_report_t expected_reports[$];
  int unsigned  error_count = 0;
  int unsigned  items_sent = 0;
  int unsigned  cycle_count = 0;
  bit           sender_gaps = 1'b1;
  bit           receiver_stalls = 1'b1;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("pure_tone_run_detector_tb NOT OK");
    $finish;
  end

  task automatic report_mismatch(string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  function automatic logic [PULSE_W-1:0] clip_pulse(int unsigned v);
    return (v > 16'hFFFF) ? 16'hFFFF : v[PULSE_W-1:0];
  endfunction

  // attempt over: queue the report and go idle
  function automatic void close_attempt(bit det, end_cause_e cause);
    tone_report_t rep;
    logic [63:0] mean;
    mean = (tone_count != 0) ? 64'(tone_sum) / 64'(tone_count) : 64'd0;
    rep.detected    = det;
    rep.pulse_count = tone_count;
    rep.mean_len    = mean[PULSE_W-1:0];
    rep.end_cause   = cause;
    expected_reports.push_back(rep);
    tone_active = 1'b0;
  endfunction

  // advance the detector copy by one accepted pulse transfer
  function automatic void track_pulse(bit start, logic [PULSE_W-1:0] len, bit eod);
    logic [63:0] lhs, rhs, diff;
    logic [4:0]  fails;
    bit          mis, sil, base;
    if (eod) begin
      if (tone_active) close_attempt(1'b0, CAUSE_EOD);
      return;
    end
    if (start) begin
      tone_active = 1'b1;
      tone_sum    = SUM_W'(len);
      tone_count  = COUNT_W'(1);
      last_pulse  = len;
      miss_run    = '0;
      return;
    end
    if (!tone_active) return;

    // exact pair test and silence test
    lhs  = 64'd100 * 64'(tone_count) * (64'(last_pulse) + 64'(len));
    rhs  = 64'd200 * 64'(tone_sum);
    diff = (lhs > rhs) ? lhs - rhs : rhs - lhs;
    mis  = diff > 64'(cfg_tol) * 64'(tone_sum);
    fails = mis ? 5'(miss_run) + 5'd1 : 5'd0;
    sil  = 64'(len) * 64'(tone_count) >= 64'(cfg_ratio) * 64'(tone_sum);
    base = (tone_sum != 0) && (MAXC_W'(tone_count) >= MAXC_W'(cfg_min_run));

    if (fails > 5'(cfg_fail)) begin
      close_attempt(base && sil, CAUSE_MISMATCH);
      return;
    end
    if (sil) begin
      close_attempt(base, CAUSE_SILENCE);
      return;
    end
    miss_run   = fails[FAIL_W-1:0];
    last_pulse = len;
    if (tone_count != COUNT_MAX) begin
      tone_sum   = tone_sum + SUM_W'(len);
      tone_count = tone_count + COUNT_W'(1);
    end
  endfunction

  // one pulse transfer, with a random gap in front; valid stays high afterwards
  task automatic send_item(bit start, logic [PULSE_W-1:0] len, bit eod);
    if (sender_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.start_req   <= start;
    in_ch.pulse_len   <= len;
    in_ch.end_of_data <= eod;
    do @(posedge clk); while (!in_ch.ready);
    track_pulse(start, len, eod);
    items_sent++;
  endtask

  // drop valid, let every pending report arrive and the block settle
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write all four registers back to back while the block is idle
  task automatic apply_config(int unsigned min_run, int unsigned tol, int unsigned ratio,
                              int unsigned fail);
    logic [CFG_DATA_W-1:0] vals[4];
    cfg_idx_e              idx;
    vals[0] = CFG_DATA_W'(min_run);
    vals[1] = CFG_DATA_W'(tol);
    vals[2] = CFG_DATA_W'(ratio);
    vals[3] = CFG_DATA_W'(fail);
    wait_idle();
    for (int i = 0; i < 4; i++) begin
      idx = cfg_idx_e'(i);
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx;
      cfg_ch.data  <= vals[i];
      do @(posedge clk); while (!cfg_ch.ready);
      case (idx)
        CFG_MIN_RUN:   cfg_min_run = vals[i][MINRUN_W-1:0];
        CFG_TOLERANCE: cfg_tol     = vals[i][TOL_W-1:0];
        CFG_SILENCE:   cfg_ratio   = vals[i][RATIO_W-1:0];
        CFG_FAIL:      cfg_fail    = vals[i][FAIL_W-1:0];
        default: ;
      endcase
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // result side: random stalls, compare each transfer with the oldest report
  initial begin
    tone_report_t want;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (expected_reports.size() == 0) begin
          report_mismatch($sformatf("unexpected result det=%0b count=%0d mean=%0d cause=%0d",
                                    out_ch.detected, out_ch.pulse_count, out_ch.mean_len,
                                    out_ch.end_cause));
        end else begin
          want = expected_reports.pop_front();
          if (out_ch.detected !== want.detected)
            report_mismatch($sformatf("detected %0b, want %0b", out_ch.detected,
                                      want.detected));
          if (out_ch.pulse_count !== want.pulse_count)
            report_mismatch($sformatf("pulse_count %0d, want %0d", out_ch.pulse_count,
                                      want.pulse_count));
          if (out_ch.mean_len !== want.mean_len)
            report_mismatch($sformatf("mean_len %0d, want %0d", out_ch.mean_len,
                                      want.mean_len));
          if (out_ch.end_cause !== want.end_cause)
            report_mismatch($sformatf("end_cause %0d, want %0d", out_ch.end_cause,
                                      want.end_cause));
        end
      end
      out_ch.ready <= !(receiver_stalls && $urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // pulse trains around a random mean, closed by silence, end of data or a new start
  task automatic test_random_runs(int unsigned n_items);
    int unsigned target, run_cap, run_len, mean, jit, roll;
    target = items_sent + n_items;
    while (items_sent < target) begin
      if ($urandom_range(0, 99) < 20) begin
        // noise
        send_item(1'($urandom_range(0, 1)), clip_pulse($urandom_range(0, 16'hFFFF)),
                  $urandom_range(0, 9) == 0);
      end else begin
        roll = $urandom_range(0, 9);
        if (roll == 0) mean = $urandom_range(0, 16'hFFFF);
        else if (roll == 1) mean = $urandom_range(0, 15);
        else mean = $urandom_range(16, 3000);
        jit = mean * cfg_tol / 400;
        run_cap = (cfg_min_run > 56) ? 60 : cfg_min_run + 4;
        run_len = $urandom_range(run_cap / 2, run_cap);
        send_item(1'b1, clip_pulse(mean), 1'b0);
        repeat (run_len) begin
          if ($urandom_range(0, 19) == 0)
            send_item(1'b0, clip_pulse($urandom_range(0, 16'hFFFF)), 1'b0);
          else
            send_item(1'b0, clip_pulse(mean + $urandom_range(0, 2 * jit) - jit), 1'b0);
        end
        roll = $urandom_range(0, 99);
        if (roll < 60)
          send_item(1'b0, clip_pulse(mean * cfg_ratio + $urandom_range(0, mean)), 1'b0);
        else if (roll < 85)
          send_item(1'($urandom_range(0, 1)), clip_pulse($urandom_range(0, 16'hFFFF)),
                    1'b1);
      end
    end
    // close any open attempt before the next register change
    send_item(1'b0, '0, 1'b1);
  endtask

  // reset values of all registers
  task automatic test_default_settings();
    test_random_runs(200);
  endtask

  task automatic test_directed_cases();
    apply_config(2, 15, 5, 0);
    // end of data and a bare pulse while idle
    send_item(1'b0, 16'd100, 1'b1);
    send_item(1'b0, 16'd77, 1'b0);
    // clean run ended by a silence pulse that also mismatches
    send_item(1'b1, 16'd100, 1'b0);
    send_item(1'b0, 16'd100, 1'b0);
    send_item(1'b0, 16'd100, 1'b0);
    send_item(1'b0, 16'd600, 1'b0);
    // end of data with a start in the same transfer
    send_item(1'b1, 16'd100, 1'b0);
    send_item(1'b0, 16'd100, 1'b0);
    send_item(1'b1, 16'd55, 1'b1);
    // restart drops the running attempt
    send_item(1'b1, 16'd100, 1'b0);
    send_item(1'b0, 16'd100, 1'b0);
    send_item(1'b1, 16'd200, 1'b0);
    send_item(1'b0, 16'd200, 1'b0);
    send_item(1'b0, 16'd1000, 1'b0);
    // mismatch and silence on the same pulse
    send_item(1'b1, 16'd100, 1'b0);
    send_item(1'b0, 16'd100, 1'b0);
    send_item(1'b0, 16'd100, 1'b0);
    send_item(1'b0, 16'd5000, 1'b0);
    // zero sum makes any pulse silence
    send_item(1'b1, 16'd0, 1'b0);
    send_item(1'b0, 16'd0, 1'b0);
    // largest pulses
    send_item(1'b1, 16'hFFFF, 1'b0);
    send_item(1'b0, 16'hFFFF, 1'b0);
    send_item(1'b0, 16'd0, 1'b0);
    send_item(1'b1, 16'hFFFF, 1'b0);
    send_item(1'b0, 16'd0, 1'b1);
  endtask

  task automatic test_register_sweep();
    apply_config(1, 0, 1, 0);
    test_random_runs(150);
    // out of range tolerance, zero minimum
    apply_config(0, 127, 15, 15);
    test_random_runs(150);
    apply_config(16'hFFFF, 100, 15, 15);
    test_random_runs(100);
    // ratio zero: every pulse is silence
    apply_config(3, 30, 0, 2);
    test_random_runs(60);
    repeat (3) begin
      apply_config($urandom_range(1, 20), $urandom_range(0, 100), $urandom_range(1, 15),
                   $urandom_range(0, 15));
      test_random_runs(150);
    end
    // stretch with no gaps and no stalls
    apply_config($urandom_range(1, 20), $urandom_range(0, 100), $urandom_range(1, 15),
                 $urandom_range(0, 15));
    sender_gaps = 1'b0;
    receiver_stalls = 1'b0;
    test_random_runs(150);
    sender_gaps = 1'b1;
    receiver_stalls = 1'b1;
  endtask

  initial begin
    in_ch.valid       = 1'b0;
    in_ch.start_req   = 1'b0;
    in_ch.pulse_len   = '0;
    in_ch.end_of_data = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = CFG_MIN_RUN;
    cfg_ch.data       = '0;
    rst_n             = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_settings();
    test_directed_cases();
    test_register_sweep();
    wait_idle();

    if (error_count == 0) begin
      $display("pure_tone_run_detector_tb OK");
    end else begin
      $display("pure_tone_run_detector_tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ptrd_pkg.sv
rtl/ptrd_if.sv
rtl/ptrd_mul.sv
rtl/ptrd_div.sv
rtl/pure_tone_run_detector.sv
rtl/ptrd_checker.sv
verif/pure_tone_run_detector_tb.sv
